### rtl/ubx_fb_pkg.sv
package ubx_fb_pkg;

    localparam int ByteWidth     = 8;
    localparam int CountWidth    = 16;
    localparam int CfgIndexWidth = 1;
    localparam int CfgDataWidth  = 8;
    localparam int QueueDepth    = 4;

    localparam logic [ByteWidth-1:0] SyncFirstReset  = 8'd181;
    localparam logic [ByteWidth-1:0] SyncSecondReset = 8'd98;

    localparam logic [CfgIndexWidth-1:0] RegSyncFirst  = 1'b0;
    localparam logic [CfgIndexWidth-1:0] RegSyncSecond = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SKIP1   = 6'b000010,
        PH_ID      = 6'b000100,
        PH_LENH    = 6'b001000,
        PH_LENL    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_ID     = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [ByteWidth-1:0] data;
        logic [ByteWidth-1:0] sum_a;
        logic [ByteWidth-1:0] sum_b;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

### rtl/ubx_fb_in_if.sv
interface ubx_fb_in_if
    import ubx_fb_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] in_byte;
    logic                 first_byte;

    modport source (output valid, output in_byte, output first_byte, input ready);
    modport sink (input valid, input in_byte, input first_byte, output ready);
endinterface

### rtl/ubx_fb_out_if.sv
interface ubx_fb_out_if
    import ubx_fb_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ByteWidth-1:0] out_byte;
    logic                 frame_end;

    modport source (output valid, output out_byte, output frame_end, input ready);
    modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

### rtl/ubx_frame_builder_unit.sv
// An accepted byte's entry is written into the queue, then the back end registers it onto tx.
// Throughput: one input byte per cycle while the queue has room; tx sends one byte per cycle
// while tx is ready and the queue holds an entry. An id byte or a final byte expands to three
// output bytes from a single queue entry; the entry queue (QUEUE_DEPTH deep) absorbs these bursts.
// Reset (rst_n, async, active low): idle, queue empty, sync bytes 181 and 98.
module ubx_frame_builder_unit
    import ubx_fb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    ubx_fb_in_if.sink                rx,
    ubx_fb_out_if.source             tx,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    logic [ByteWidth-1:0] sync_first_reg;
    logic [ByteWidth-1:0] sync_second_reg;
    queue_status_t        status;
    logic                 push;
    logic                 pop;
    entry_t               push_entry;
    entry_t               head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SyncFirstReset;
            sync_second_reg <= SyncSecondReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegSyncFirst:  sync_first_reg  <= cfg_data[ByteWidth-1:0];
                RegSyncSecond: sync_second_reg <= cfg_data[ByteWidth-1:0];
                default:       ;
            endcase
        end
    end

    ubx_fb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .status     (status),
        .push       (push),
        .push_entry (push_entry)
    );

    ubx_fb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    ubx_fb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .status      (status),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .pop         (pop),
        .tx          (tx)
    );

endmodule

### rtl/ubx_fb_front.sv
module ubx_fb_front
    import ubx_fb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ubx_fb_in_if.sink     rx,
    input  queue_status_t status,
    output logic          push,
    output entry_t        push_entry
);

    phase_t                phase_reg, phase_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [ByteWidth-1:0]  sum_a_reg, sum_a_next;
    logic [ByteWidth-1:0]  sum_b_reg, sum_b_next;
    logic [ByteWidth-1:0]  acc_a;
    logic [ByteWidth-1:0]  acc_b;
    logic [CountWidth-1:0] len_full;
    logic [CountWidth-1:0] count_dec;
    logic                  accept;

    assign rx.ready  = !status.full;
    assign accept    = rx.valid && rx.ready;
    assign acc_a     = sum_a_reg + rx.in_byte;
    assign acc_b     = sum_b_reg + acc_a;
    assign len_full  = count_reg | {{(CountWidth-ByteWidth){1'b0}}, rx.in_byte};
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        push             = 1'b0;
        push_entry.kind  = KIND_BYTE;
        push_entry.data  = rx.in_byte;
        push_entry.sum_a = acc_a;
        push_entry.sum_b = acc_b;
        if (accept)
        begin
            if (rx.first_byte)
            begin
                phase_next = PH_SKIP1;
                count_next = '0;
                sum_a_next = '0;
                sum_b_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_SKIP1:
                    begin
                        phase_next = PH_ID;
                    end
                    PH_ID:
                    begin
                        sum_a_next      = acc_a;
                        sum_b_next      = acc_b;
                        push            = 1'b1;
                        push_entry.kind = KIND_ID;
                        phase_next      = PH_LENH;
                    end
                    PH_LENH:
                    begin
                        sum_a_next = acc_a;
                        sum_b_next = acc_b;
                        push       = 1'b1;
                        count_next = {rx.in_byte, {(CountWidth-ByteWidth){1'b0}}};
                        phase_next = PH_LENL;
                    end
                    PH_LENL:
                    begin
                        sum_a_next = acc_a;
                        sum_b_next = acc_b;
                        push       = 1'b1;
                        count_next = len_full;
                        if (len_full == '0)
                        begin
                            push_entry.kind = KIND_FINISH;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        sum_a_next = acc_a;
                        sum_b_next = acc_b;
                        push       = 1'b1;
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            push_entry.kind = KIND_FINISH;
                            phase_next      = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx.first_byte) |=> (phase_reg == PH_SKIP1 && sum_a_reg == '0))
        else $error("first byte did not restart the message");

endmodule

### rtl/ubx_fb_queue.sv
module ubx_fb_queue
    import ubx_fb_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  entry_t        push_entry,
    input  logic          pop,
    output entry_t        head,
    output queue_status_t status
);

    localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(DEPTH - 1);
    localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

    entry_t                slots_reg [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] fill_reg, fill_next;

    assign head         = slots_reg[rd_ptr_reg];
    assign status.empty = (fill_reg == '0);
    assign status.full  = (fill_reg == FullCount);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("pop from an empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FullCount)
        else $error("queue fill count out of range");

endmodule

### rtl/ubx_fb_back.sv
module ubx_fb_back
    import ubx_fb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  entry_t               head,
    input  queue_status_t        status,
    input  logic [ByteWidth-1:0] sync_first,
    input  logic [ByteWidth-1:0] sync_second,
    output logic                 pop,
    ubx_fb_out_if.source         tx
);

    localparam logic [1:0] StepFirst  = 2'd0;
    localparam logic [1:0] StepSecond = 2'd1;
    localparam logic [1:0] StepThird  = 2'd2;

    logic                 out_valid_reg;
    logic [ByteWidth-1:0] out_byte_reg;
    logic                 frame_end_reg;
    logic [1:0]           step_reg, step_next;
    logic [1:0]           last_step;
    logic [ByteWidth-1:0] sel_byte;
    logic                 sel_end;
    logic                 load;

    assign tx.valid     = out_valid_reg;
    assign tx.out_byte  = out_byte_reg;
    assign tx.frame_end = frame_end_reg;

    assign load = !out_valid_reg || tx.ready;
    assign pop  = load && !status.empty && (step_reg == last_step);

    always_comb
    begin
        last_step = StepThird;
        sel_byte  = head.data;
        sel_end   = 1'b0;
        case (head.kind)
            KIND_ID:
            begin
                case (step_reg)
                    StepFirst:  sel_byte = sync_first;
                    StepSecond: sel_byte = sync_second;
                    default:    sel_byte = head.data;
                endcase
            end
            KIND_FINISH:
            begin
                case (step_reg)
                    StepFirst:  sel_byte = head.data;
                    StepSecond: sel_byte = head.sum_a;
                    default:
                    begin
                        sel_byte = head.sum_b;
                        sel_end  = 1'b1;
                    end
                endcase
            end
            default:
            begin
                last_step = StepFirst;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (load && !status.empty)
        begin
            step_next = (step_reg == last_step) ? StepFirst : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= StepFirst;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                out_valid_reg <= !status.empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !status.empty)
        begin
            out_byte_reg  <= sel_byte;
            frame_end_reg <= sel_end;
        end
    end

    a_step_holds_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != StepFirst) |-> !status.empty)
        else $error("entry left the queue before all its bytes were sent");

    a_end_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !status.empty && sel_end) |-> (head.kind == KIND_FINISH && pop))
        else $error("frame end outside the last checksum byte");

endmodule
